[rtl/okc_pkg.sv]
// Shared constants, types and helper functions for the online k-means classifier.
// Used by every module of the block but okc_ram; depends on nothing else.
package okc_pkg;

  // Sizing of the block.
  localparam int MAX_CLUSTERS = 10;
  localparam int MAX_FEATURES = 64;
  localparam int FRAC_BITS    = 16;

  // Fixed field widths.
  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int NCL_W  = 4;
  localparam int FLEN_W = 7;
  localparam int MDEP_W = 16;
  localparam int CFG_W  = 16;
  localparam int CFG_AW = 2;
  localparam int COUNT_W = 16;

  // Derived widths.
  localparam int INT_W      = DATA_W - FRAC_BITS;
  localparam int CNT_W      = $clog2(MAX_FEATURES + 2);
  localparam int LEN_CMP_W  = (CNT_W > FLEN_W) ? CNT_W : FLEN_W;
  localparam int VB_AW      = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CL_W       = $clog2(MAX_CLUSTERS);
  localparam int SEED_W     = $clog2(MAX_CLUSTERS + 1);
  localparam int MEAN_DEPTH = MAX_CLUSTERS * MAX_FEATURES;
  localparam int MEAN_AW    = $clog2(MEAN_DEPTH);
  localparam int DIFF_W     = DATA_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int ACC_W      = SQ_W + $clog2(MAX_FEATURES + 1);
  localparam int DVD_W      = DIFF_W;
  // Divisor width covers 10^8; a 16-bit integer part needs at most 10^5.
  localparam int DIV_W      = 27;

  localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1 << FRAC_BITS);
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_AW-1:0] {
    REG_NUM_CLUSTERS   = 2'd0,
    REG_FEATURE_LENGTH = 2'd1,
    REG_MEMORY_DEPTH   = 2'd2
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_NORM,
    S_NORM_WAIT,
    S_STORE,
    S_CHECK,
    S_SEED_RD,
    S_SEED_WR,
    S_DIST_RD,
    S_DIST_SUB,
    S_DIST_MUL,
    S_DIST_ACC,
    S_DIST_CMP,
    S_UPD_INC,
    S_UPD_RD,
    S_UPD_DIV,
    S_UPD_WAIT,
    S_UPD_WR,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic norm_start;
    logic store_elem;
    logic end_vec;
    logic idx_clear;
    logic seed_write;
    logic seed_finish;
    logic dist_begin;
    logic dist_sub;
    logic dist_mul;
    logic dist_acc;
    logic dist_cmp;
    logic upd_inc;
    logic upd_start;
    logic upd_write;
    logic rd_best;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic big;
    logic div_done;
    logic last_flag;
    logic vec_ok;
    logic seeding;
    logic elem_last;
    logic clus_last;
    logic out_free;
  } status_t;

  // Power of ten whose exponent is the decimal digit count of an integer part.
  function automatic logic [DIV_W-1:0] norm_divisor(input logic [INT_W-1:0] ip);
    logic [DIV_W-1:0] p;
    longint thr;
    p   = DIV_W'(10);
    thr = 10;
    for (int j = 1; j < 8; j++) begin
      if (longint'(ip) >= thr) begin
        p = DIV_W'(thr * 10);
      end
      thr = thr * 10;
    end
    return p;
  endfunction

endpackage

[rtl/okc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module okc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/okc_div.sv]
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on okc_pkg for operand widths.
module okc_div
  import okc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0]  work;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W:0]    rem_sh;
  logic              fits;

  // Shift in the next dividend bit and try the subtraction.
  assign rem_sh   = {rem, work[DVD_W-1]};
  assign fits     = rem_sh >= {1'b0, dsr};
  assign quotient = work;

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      work <= {work[DVD_W-2:0], fits};
      rem  <= fits ? DIV_W'(rem_sh - {1'b0, dsr}) : rem_sh[DIV_W-1:0];
    end
  end

endmodule

[rtl/okc_ctrl.sv]
// Controller state machine of the classifier: sequences element intake,
// seeding, distance search, mean update and result output. Depends on okc_pkg.
module okc_ctrl
  import okc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_NORM;
      S_NORM:      state_next = status.big ? S_NORM_WAIT : S_STORE;
      S_NORM_WAIT: if (status.div_done) state_next = S_STORE;
      S_STORE:     state_next = status.last_flag ? S_CHECK : S_IDLE;
      S_CHECK: begin
        if (!status.vec_ok) state_next = S_IDLE;
        else if (status.seeding) state_next = S_SEED_RD;
        else state_next = S_DIST_RD;
      end
      S_SEED_RD:   state_next = S_SEED_WR;
      S_SEED_WR:   state_next = status.elem_last ? S_OUT : S_SEED_RD;
      S_DIST_RD:   state_next = S_DIST_SUB;
      S_DIST_SUB:  state_next = S_DIST_MUL;
      S_DIST_MUL:  state_next = S_DIST_ACC;
      S_DIST_ACC:  state_next = status.elem_last ? S_DIST_CMP : S_DIST_RD;
      S_DIST_CMP:  state_next = status.clus_last ? S_UPD_INC : S_DIST_RD;
      S_UPD_INC:   state_next = S_UPD_RD;
      S_UPD_RD:    state_next = S_UPD_DIV;
      S_UPD_DIV:   state_next = S_UPD_WAIT;
      S_UPD_WAIT:  if (status.div_done) state_next = S_UPD_WR;
      S_UPD_WR:    state_next = status.elem_last ? S_OUT : S_UPD_RD;
      S_OUT:       if (status.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:  cmd.load_in = in_valid;
      S_NORM:  cmd.norm_start = status.big;
      S_STORE: cmd.store_elem = 1'b1;
      S_CHECK: begin
        cmd.end_vec    = 1'b1;
        cmd.idx_clear  = 1'b1;
        cmd.dist_begin = 1'b1;
      end
      S_SEED_WR: begin
        cmd.seed_write  = 1'b1;
        cmd.seed_finish = status.elem_last;
      end
      S_DIST_SUB: cmd.dist_sub = 1'b1;
      S_DIST_MUL: cmd.dist_mul = 1'b1;
      S_DIST_ACC: cmd.dist_acc = 1'b1;
      S_DIST_CMP: begin
        cmd.dist_cmp  = 1'b1;
        cmd.idx_clear = 1'b1;
      end
      S_UPD_INC: begin
        cmd.upd_inc   = 1'b1;
        cmd.idx_clear = 1'b1;
      end
      S_UPD_RD:   cmd.rd_best = 1'b1;
      S_UPD_DIV: begin
        cmd.rd_best   = 1'b1;
        cmd.upd_start = 1'b1;
      end
      S_UPD_WAIT: cmd.rd_best = 1'b1;
      S_UPD_WR: begin
        cmd.rd_best   = 1'b1;
        cmd.upd_write = 1'b1;
      end
      S_OUT:   cmd.emit = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/okc_dp.sv]
// Datapath of the classifier: configuration registers, vector and mean
// memories, distance accumulator, shared divider and result register.
// Depends on okc_pkg, okc_ram and okc_div.
module okc_dp
  import okc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_AW-1:0]        cfg_addr,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic signed [DATA_W-1:0] sample_value,
  input  logic                     last_element,
  input  logic                     out_stall,
  input  cmd_t                     cmd,
  output status_t                  status,
  output logic                     out_valid,
  output logic [IDX_W-1:0]         cluster_index
);

  // Configuration registers.
  logic [NCL_W-1:0]  num_clusters;
  logic [FLEN_W-1:0] feature_length;
  logic [MDEP_W-1:0] memory_depth;

  // Control and working registers.
  logic [DATA_W-1:0]  in_val;
  logic               in_last;
  logic               in_big;
  logic [CNT_W-1:0]   elem_cnt;
  logic               nonzero;
  logic [CNT_W-1:0]   vec_len;
  logic [SEED_W-1:0]  seeded;
  logic [CNT_W-1:0]   idx;
  logic [CL_W-1:0]    clus;
  logic [CL_W-1:0]    best;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   best_acc;
  logic [DIFF_W-1:0]  abs_diff;
  logic [SQ_W-1:0]    sq;
  logic [DATA_W-1:0]  upd_mean;
  logic               upd_neg;
  logic [IDX_W-1:0]   res_idx;
  logic [COUNT_W-1:0] counts [MAX_CLUSTERS];

  // Memory and divider connections.
  logic [DATA_W-1:0]  vb_rdata;
  logic [DATA_W-1:0]  mean_rdata;
  logic               vb_we;
  logic               mean_we;
  logic [MEAN_AW-1:0] mean_waddr;
  logic [MEAN_AW-1:0] mean_raddr;
  logic [DATA_W-1:0]  mean_wdata;
  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic [DIV_W-1:0]   div_divisor;
  logic               div_done;
  logic [DVD_W-1:0]   div_quot;

  // Combinational helpers.
  logic [SEED_W-1:0]        k_use;
  logic [CNT_W-1:0]         idx_plus;
  logic [CL_W-1:0]          rd_clus;
  logic signed [DIFF_W-1:0] dist_diff;
  logic signed [DIFF_W-1:0] upd_diff;
  logic [DIFF_W-1:0]        upd_mag;
  logic [DIFF_W-1:0]        upd_sum;
  logic [DIFF_W-1:0]        quot_signed;
  logic [DATA_W-1:0]        store_val;
  logic [COUNT_W-1:0]       best_count;

  // Clusters in use, clamped to the supported range.
  always_comb begin
    if (int'(num_clusters) < 2) begin
      k_use = SEED_W'(2);
    end else if (int'(num_clusters) > MAX_CLUSTERS) begin
      k_use = SEED_W'(MAX_CLUSTERS);
    end else begin
      k_use = SEED_W'(num_clusters);
    end
  end

  assign idx_plus   = idx + CNT_W'(1);
  assign rd_clus    = cmd.rd_best ? best : clus;
  assign best_count = counts[best];

  // Status to the controller.
  assign status.big       = in_big;
  assign status.div_done  = div_done;
  assign status.last_flag = in_last;
  assign status.vec_ok    = nonzero
                            && (LEN_CMP_W'(elem_cnt) == LEN_CMP_W'(feature_length))
                            && (int'(elem_cnt) <= MAX_FEATURES);
  assign status.seeding   = seeded < k_use;
  assign status.elem_last = (idx_plus == vec_len);
  assign status.clus_last = (SEED_W'(clus) + SEED_W'(1)) == k_use;
  assign status.out_free  = !out_valid;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters   <= NCL_W'(2);
      feature_length <= FLEN_W'(16);
      memory_depth   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NUM_CLUSTERS:   num_clusters   <= cfg_wdata[NCL_W-1:0];
        REG_FEATURE_LENGTH: feature_length <= cfg_wdata[FLEN_W-1:0];
        REG_MEMORY_DEPTH:   memory_depth   <= cfg_wdata[MDEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input capture; an element above 1.0 goes through the divider.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_val  <= sample_value;
      in_last <= last_element;
      in_big  <= sample_value > ONE_Q;
    end
  end

  assign store_val = in_big ? div_quot[DATA_W-1:0] : in_val;
  assign vb_we     = cmd.store_elem && (int'(elem_cnt) < MAX_FEATURES);

  // Divider sharing between normalization and mean update.
  assign dist_diff = $signed({mean_rdata[DATA_W-1], mean_rdata})
                     - $signed({vb_rdata[DATA_W-1], vb_rdata});
  assign upd_diff  = $signed({vb_rdata[DATA_W-1], vb_rdata})
                     - $signed({mean_rdata[DATA_W-1], mean_rdata});
  assign upd_mag   = upd_diff[DIFF_W-1] ? DIFF_W'(-upd_diff) : DIFF_W'(upd_diff);

  assign div_start = cmd.norm_start || cmd.upd_start;
  always_comb begin
    if (cmd.upd_start) begin
      div_dividend = upd_mag;
      div_divisor  = (memory_depth != '0) ? DIV_W'(memory_depth) : DIV_W'(best_count);
    end else begin
      div_dividend = DVD_W'(in_val);
      div_divisor  = norm_divisor(in_val[DATA_W-1:FRAC_BITS]);
    end
  end

  // New mean element: mean plus the signed truncated quotient.
  assign quot_signed = upd_neg ? DIFF_W'(-div_quot) : div_quot;
  assign upd_sum     = {upd_mean[DATA_W-1], upd_mean} + quot_signed;

  // Mean memory addressing.
  assign mean_raddr = MEAN_AW'(rd_clus) * MEAN_AW'(MAX_FEATURES) + MEAN_AW'(idx);
  assign mean_we    = cmd.seed_write || cmd.upd_write;
  always_comb begin
    if (cmd.upd_write) begin
      mean_waddr = MEAN_AW'(best) * MEAN_AW'(MAX_FEATURES) + MEAN_AW'(idx);
      mean_wdata = upd_sum[DATA_W-1:0];
    end else begin
      mean_waddr = MEAN_AW'(seeded) * MEAN_AW'(MAX_FEATURES) + MEAN_AW'(idx);
      mean_wdata = vb_rdata;
    end
  end

  // Vector bookkeeping, index walk and cluster seeding.
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_cnt <= '0;
      nonzero  <= 1'b0;
      seeded   <= '0;
      idx      <= '0;
      clus     <= '0;
      vec_len  <= '0;
      for (int j = 0; j < MAX_CLUSTERS; j++) begin
        counts[j] <= '0;
      end
    end else begin
      if (cmd.store_elem) begin
        if (store_val != '0 || in_val != '0) begin
          nonzero <= nonzero || (in_val != '0);
        end
        if (int'(elem_cnt) <= MAX_FEATURES) begin
          elem_cnt <= elem_cnt + CNT_W'(1);
        end
      end
      if (cmd.end_vec) begin
        elem_cnt <= '0;
        nonzero  <= 1'b0;
        vec_len  <= elem_cnt;
      end
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.seed_write || cmd.dist_acc || cmd.upd_write) begin
        idx <= idx_plus;
      end
      if (cmd.dist_begin) begin
        clus <= '0;
      end else if (cmd.dist_cmp) begin
        clus <= clus + CL_W'(1);
      end
      if (cmd.seed_finish) begin
        counts[seeded[CL_W-1:0]] <= COUNT_W'(1);
        seeded <= seeded + SEED_W'(1);
      end
      if (cmd.upd_inc && best_count != COUNT_SAT) begin
        counts[best] <= best_count + COUNT_W'(1);
      end
    end
  end

  // Distance pipeline: difference, square, accumulate, compare.
  always_ff @(posedge clk) begin
    if (cmd.dist_sub) begin
      abs_diff <= dist_diff[DIFF_W-1] ? DIFF_W'(-dist_diff) : DIFF_W'(dist_diff);
    end
    if (cmd.dist_mul) begin
      sq <= abs_diff * abs_diff;
    end
    if (cmd.dist_begin || cmd.dist_cmp) begin
      acc <= '0;
    end else if (cmd.dist_acc) begin
      acc <= acc + ACC_W'(sq);
    end
    if (cmd.dist_cmp && (clus == '0 || acc < best_acc)) begin
      best     <= clus;
      best_acc <= acc;
    end
    if (cmd.upd_start) begin
      upd_mean <= mean_rdata;
      upd_neg  <= upd_diff[DIFF_W-1];
    end
    if (cmd.seed_finish) begin
      res_idx <= IDX_W'(seeded);
    end else if (cmd.upd_inc) begin
      res_idx <= IDX_W'(best);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cluster_index <= res_idx;
    end
  end

  // Normalized vector buffer.
  okc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_FEATURES)
  ) u_vbuf (
    .clk   (clk),
    .we    (vb_we),
    .waddr (elem_cnt[VB_AW-1:0]),
    .wdata (store_val),
    .raddr (idx[VB_AW-1:0]),
    .rdata (vb_rdata)
  );

  // Cluster means, one row of MAX_FEATURES entries per cluster.
  okc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEAN_DEPTH)
  ) u_means (
    .clk   (clk),
    .we    (mean_we),
    .waddr (mean_waddr),
    .wdata (mean_wdata),
    .raddr (mean_raddr),
    .rdata (mean_rdata)
  );

  // Shared divider.
  okc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

endmodule

[rtl/online_kmeans_classifier.sv]
// Top level of the online k-means classifier: controller plus datapath.
// Depends on okc_pkg, okc_ctrl and okc_dp.
//
//   Channel  Direction  Handshake          Payload
//   input    in         in_valid/in_stall  sample_value, last_element
//   output   out        out_valid/out_stall cluster_index
//   config   in         cfg_we             cfg_addr, cfg_wdata
//
// An element passes IDLE, NORM and STORE, and NORM_WAIT when it is above 1.0
// and goes through the 33-step serial divider. At the end of a vector of L
// elements, seeding copies it to a new cluster's means, or the nearest of K
// clusters has its L mean elements updated by the divider. One transaction
// is in work at a time. Reset is synchronous and clears all control state.
// A stalled output holds its result; the next vector's result waits for it.
module online_kmeans_classifier
  import okc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_AW-1:0]        cfg_addr,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] sample_value,
  input  logic                     last_element,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         cluster_index
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  okc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  okc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .sample_value  (sample_value),
    .last_element  (last_element),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .cluster_index (cluster_index)
  );

endmodule

[tb/online_kmeans_classifier_test.sv]
// Self-checking testbench for the online k-means classifier.
// Depends on okc_pkg and the online_kmeans_classifier RTL.
`timescale 1ns / 1ps

module online_kmeans_classifier_test;
  import okc_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } elem_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] sample_value = '0;
  logic last_element = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] cluster_index;

  online_kmeans_classifier dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state.
  logic [3:0] k_cfg = 4'd2;
  logic [6:0] len_cfg = 7'd16;
  logic [15:0] mem_cfg = 16'd0;
  logic signed [31:0] vec_buf [64];
  logic signed [31:0] means [10][64];
  int unsigned counts [10];
  int unsigned elem_cnt = 0;
  bit nonzero = 0;
  int unsigned seeded = 0;

  elem_t pending_elems[$];
  logic [3:0] expected_idx[$];
  int errors = 0;
  int results_seen = 0;
  int vectors_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;

  // Tracks whether the element on the bus was accepted at the last rising edge.
  bit in_stall_seen = 1'b1;

  function automatic logic signed [31:0] scale_down(logic signed [31:0] v);
    logic [31:0] ip;
    logic [31:0] p;
    if (v <= 32'sh10000) return v;
    ip = 32'(v) >> 16;
    p = 1;
    while (ip > 0) begin
      ip = ip / 10;
      p = p * 10;
    end
    return $signed(32'(v) / p);
  endfunction

  // Advance the predictor by one element; push an expected index if any.
  task automatic predict_element(elem_t e);
    int unsigned len, k, best;
    longint d, dv, m;
    logic [127:0] sq_sum, best_dist;
    if (elem_cnt < 64) vec_buf[elem_cnt] = scale_down(e.value);
    if (e.value != 0) nonzero = 1;
    if (elem_cnt <= 64) elem_cnt++;
    if (!e.last) return;
    len = elem_cnt;
    elem_cnt = 0;
    if (!nonzero || len != len_cfg || len > 64) begin
      nonzero = 0;
      return;
    end
    nonzero = 0;
    k = (k_cfg < 2) ? 2 : (k_cfg > 10) ? 10 : k_cfg;
    if (seeded < k) begin
      for (int i = 0; i < len; i++) means[seeded][i] = vec_buf[i];
      counts[seeded] = 1;
      expected_idx.push_back(4'(seeded));
      seeded++;
      return;
    end
    best = 0;
    best_dist = '0;
    for (int c = 0; c < k; c++) begin
      sq_sum = '0;
      for (int i = 0; i < len; i++) begin
        d = longint'(means[c][i]) - longint'(vec_buf[i]);
        // The square fits in 64 unsigned bits but not in a signed longint.
        sq_sum += 128'($unsigned(d * d));
      end
      if (c == 0 || sq_sum < best_dist) begin
        best = c;
        best_dist = sq_sum;
      end
    end
    if (counts[best] < 65535) counts[best]++;
    dv = (mem_cfg != 0) ? longint'(mem_cfg) : longint'(counts[best]);
    for (int i = 0; i < len; i++) begin
      m = means[best][i];
      d = longint'(vec_buf[i]) - m;
      means[best][i] = 32'(m + d / dv);
    end
    expected_idx.push_back(4'(best));
  endtask

  // Driver: offers queued elements, changing inputs on the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_seen) begin
        // Previous element was not taken; hold it.
      end else if (pending_elems.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_value <= pending_elems[0].value;
        last_element <= pending_elems[0].last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: feeds accepted elements to the predictor and checks each accepted result.
  always @(posedge clk) begin
    if (rst) begin
      in_stall_seen <= 1'b1;
    end else begin
      in_stall_seen <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_element(pending_elems.pop_front());
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_idx.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual cluster_index=%0d", $time, cluster_index);
        end else begin
          if (cluster_index !== expected_idx[0]) begin
            errors++;
            $display("%0t: cluster_index mismatch, expected %0d actual %0d", $time,
                     expected_idx[0], cluster_index);
          end
          void'(expected_idx.pop_front());
        end
      end
    end
  end

  // Queue one vector of n elements; the flag is set on the final one.
  task automatic add_vector(int n, int mode);
    elem_t e;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: e.value = $urandom();
        1: e.value = 32'($urandom_range(0, 32'h30000)) - 32'sh18000;
        2: e.value = 32'sh0;
        default: e.value = ($urandom_range(3) == 0) ? 32'($urandom()) :
                           32'($urandom_range(0, 32'h20000)) - 32'sh10000;
      endcase
      e.last = (i == n - 1);
      pending_elems.push_back(e);
    end
    vectors_sent++;
  endtask

  task automatic wait_drained();
    while (pending_elems.size() > 0 || expected_idx.size() > 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  // Registers change only when no transaction is queued or in work.
  task automatic write_reg(cfg_reg_t r, logic [15:0] v);
    while (pending_elems.size() > 0 || expected_idx.size() > 0 || in_stall)
      @(negedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_NUM_CLUSTERS: k_cfg = v[3:0];
      REG_FEATURE_LENGTH: len_cfg = v[6:0];
      default: mem_cfg = v;
    endcase
  endtask

  // Random vectors: mostly correct length, some wrong or all-zero or overlong.
  task automatic random_phase(int n_vec, int idle, int stall);
    int r;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int v = 0; v < n_vec; v++) begin
      r = $urandom_range(19);
      if (r == 0) add_vector(len_cfg, 2);
      else if (r == 1) add_vector($urandom_range(1, 8), 3);
      else if (r == 2 && len_cfg < 8 && v % 5 == 0) add_vector(66, 3);
      else add_vector(len_cfg, (r < 8) ? 1 : 3);
    end
    while (pending_elems.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int c = 0; c < 10; c++) counts[c] = 0;

    // Wide vectors first, so every mean element later read has been seeded.
    write_reg(REG_FEATURE_LENGTH, 16'd64);
    random_phase(3, 6, 6);
    wait_drained();

    // Directed: reset config, extremes of value, zero vector, wrong length.
    write_reg(REG_FEATURE_LENGTH, 16'd2);
    write_reg(REG_NUM_CLUSTERS, 16'd2);
    write_reg(REG_MEMORY_DEPTH, 16'd0);
    pending_elems.push_back('{32'sh7fffffff, 1'b0});
    pending_elems.push_back('{32'sh80000000, 1'b1});
    pending_elems.push_back('{32'sh00010000, 1'b0});
    pending_elems.push_back('{32'sh00010001, 1'b1});
    add_vector(2, 2);
    add_vector(3, 1);
    add_vector(1, 1);
    pending_elems.push_back('{32'shffffffff, 1'b0});
    pending_elems.push_back('{32'sh0098967f, 1'b1});
    add_vector(2, 0);
    wait_drained();

    // Phase with many clusters, length one, no idling.
    write_reg(REG_NUM_CLUSTERS, 16'd10);
    write_reg(REG_FEATURE_LENGTH, 16'd1);
    random_phase(120, 0, 0);
    // Out-of-range cluster counts act as clamped values.
    write_reg(REG_NUM_CLUSTERS, 16'd15);
    write_reg(REG_MEMORY_DEPTH, 16'd65535);
    random_phase(60, 51, 0);
    write_reg(REG_NUM_CLUSTERS, 16'd0);
    write_reg(REG_MEMORY_DEPTH, 16'd3);
    random_phase(80, 0, 51);
    wait_drained();

    // Long hold-off: receiver stalls while the sender keeps offering.
    write_reg(REG_NUM_CLUSTERS, 16'd4);
    write_reg(REG_MEMORY_DEPTH, 16'd1);
    hold_off = 1;
    fork
      random_phase(20, 0, 0);
      begin
        repeat (4000) @(posedge clk);
        hold_off = 0;
      end
    join
    wait_drained();

    // Length-one vectors under mixed idling, with a zero length in between.
    write_reg(REG_MEMORY_DEPTH, 16'd0);
    write_reg(REG_NUM_CLUSTERS, 16'd2);
    write_reg(REG_FEATURE_LENGTH, 16'd1);
    random_phase(130, 6, 6);
    write_reg(REG_FEATURE_LENGTH, 16'd0);
    random_phase(20, 0, 0);
    write_reg(REG_FEATURE_LENGTH, 16'd1);
    random_phase(130, 51, 51);
    write_reg(REG_MEMORY_DEPTH, 16'd0);
    random_phase(130, 0, 0);
    wait_drained();

    $display("Sent %0d vectors; %0d cluster indices checked across several settings.",
             vectors_sent, results_seen);
    if (errors == 0) begin
      $display("PASS online_kmeans_classifier");
    end else begin
      $display("FAIL online_kmeans_classifier");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL online_kmeans_classifier");
    $finish;
  end

endmodule

[online_kmeans_classifier.f]
rtl/okc_pkg.sv
rtl/okc_ram.sv
rtl/okc_div.sv
rtl/okc_ctrl.sv
rtl/okc_dp.sv
rtl/online_kmeans_classifier.sv
tb/online_kmeans_classifier_test.sv
